### design/aes_pkg.sv
// Package with AES types, constants and the S-box function.
package aes_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int NUM_KEYS   = 11;

    typedef logic [7:0]   t_byte;
    typedef logic [31:0]  t_col;
    typedef logic [127:0] t_block;

    // command carried in tuser
    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_CRYPT = 1'b1
    } t_cmd;

    function automatic t_byte sbox(input t_byte a);
        t_byte r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic t_byte xtime(input t_byte v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN
    } t_state;

    // controls sent from the sequencer to every column cell
    typedef struct packed {
        logic load;   // take plaintext ^ key 0
        logic step;   // do one round
        logic mix;    // round includes MixColumns
    } t_cell_ctl;

endpackage

### design/aes_col_cell.sv
// One column cell: holds a 32-bit state column and does one round step on it.
module aes_col_cell (
    input  logic                i_clk,
    input  aes_pkg::t_cell_ctl  i_ctl,
    input  aes_pkg::t_col       i_load,      // plaintext column ^ key column
    input  aes_pkg::t_byte [3:0] i_shift,    // bytes handed in by neighbor cells
    input  aes_pkg::t_col       i_key,
    output aes_pkg::t_col       o_col
);
    aes_pkg::t_col r_col;
    aes_pkg::t_byte [3:0] w_sb;
    aes_pkg::t_byte [3:0] w_mx;
    aes_pkg::t_col n_col;

    // byte r of column lives in bits [31-8r -: 8]
    assign o_col = r_col;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            w_sb[r] = aes_pkg::sbox(i_shift[r]);
        end
        w_mx[0] = aes_pkg::xtime(w_sb[0]) ^ aes_pkg::xtime(w_sb[1]) ^ w_sb[1] ^ w_sb[2] ^ w_sb[3];
        w_mx[1] = w_sb[0] ^ aes_pkg::xtime(w_sb[1]) ^ aes_pkg::xtime(w_sb[2]) ^ w_sb[2] ^ w_sb[3];
        w_mx[2] = w_sb[0] ^ w_sb[1] ^ aes_pkg::xtime(w_sb[2]) ^ aes_pkg::xtime(w_sb[3]) ^ w_sb[3];
        w_mx[3] = aes_pkg::xtime(w_sb[0]) ^ w_sb[0] ^ w_sb[1] ^ w_sb[2] ^ aes_pkg::xtime(w_sb[3]);
        if (!i_ctl.mix) begin
            w_mx = w_sb;
        end
        n_col = r_col;
        if (i_ctl.load) begin
            n_col = i_load;
        end else if (i_ctl.step) begin
            n_col = {w_mx[0], w_mx[1], w_mx[2], w_mx[3]} ^ i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
    end
endmodule

### design/aes_key_store.sv
// Round key store: eleven 128-bit keys, written and read in clocked blocks.
module aes_key_store (
    input  logic         i_clk,
    input  logic         i_wr,
    input  logic [3:0]   i_wr_slot,
    input  aes_pkg::t_block i_wr_key,
    input  logic [3:0]   i_rd_slot,
    output aes_pkg::t_block o_rd_key
);
    aes_pkg::t_block r_mem [aes_pkg::NUM_KEYS];
    aes_pkg::t_block r_rd;

    assign o_rd_key = r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[i_wr_slot] <= i_wr_key;
        end
        if (i_rd_slot < 4'(aes_pkg::NUM_KEYS)) begin
            r_rd <= r_mem[i_rd_slot];
        end
    end
endmodule

### design/aes128_block_encrypt.sv
// Top level: AES-128 encrypt core with a row of four column cells.
// Sequence: an encrypt item is taken and key 0 is read from the key store, the initial
// key add loads the cells, ten rounds follow one per cycle, and the result is
// captured into the output register, which sets result valid.
// One encrypt is in work at a time; the next item is taken after the result is
// captured, while a load item leaves the input free. A waiting result does not block
// the input; only the capture waits while the previous result is still unread.
// Reset (synchronous, active low) clears the sequencer and the output valid.
module aes128_block_encrypt (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: [3:0] key_slot, [67:4] block_high, [131:68] block_low, [135:132] zero
    input  logic [135:0] s_axis_tdata,
    // tuser: command
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: [63:0] cipher_high, [127:64] cipher_low
    output logic [127:0] m_axis_tdata
);
    aes_pkg::t_state r_state, n_state;
    logic [3:0] r_round, n_round;
    aes_pkg::t_block r_pt;
    logic r_out_valid, n_out_valid;
    aes_pkg::t_block r_out;
    aes_pkg::t_cell_ctl w_ctl;
    aes_pkg::t_block w_key;
    aes_pkg::t_col [3:0] w_col;
    logic [3:0] w_rd_slot;
    logic w_acc, w_wr, w_cap;

    // accept only while no encryption is running
    assign s_axis_tready = (r_state == aes_pkg::ST_IDLE);
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_wr  = w_acc && (s_axis_tuser == aes_pkg::CMD_LOAD);

    // read key 0 at accept, then each next key in the cycle before its round uses it
    assign w_rd_slot = w_acc ? 4'd0 : r_round;

    aes_key_store u_keys (
        .i_clk     (i_clk),
        .i_wr      (w_wr && (s_axis_tdata[3:0] < 4'(aes_pkg::NUM_KEYS))),
        .i_wr_slot (s_axis_tdata[3:0]),
        .i_wr_key  ({s_axis_tdata[67:4], s_axis_tdata[131:68]}),
        .i_rd_slot (w_rd_slot),
        .o_rd_key  (w_key)
    );

    // cell c holds state column c; ShiftRows hands byte r from cell (c+r)%4
    for (genvar c = 0; c < 4; c++) begin : g_cell
        aes_pkg::t_byte [3:0] w_sh;
        for (genvar r = 0; r < 4; r++) begin : g_row
            assign w_sh[r] = w_col[(c + r) % 4][31 - 8*r -: 8];
        end
        aes_col_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_load  (r_pt[127 - 32*c -: 32] ^ w_key[127 - 32*c -: 32]),
            .i_shift (w_sh),
            .i_key   (w_key[127 - 32*c -: 32]),
            .o_col   (w_col[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aes_pkg::ST_IDLE;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_pt <= {s_axis_tdata[67:4], s_axis_tdata[131:68]};
        end
        if (w_cap) begin
            r_out <= {w_col[0], w_col[1], w_col[2], w_col[3]};
        end
    end

    // r_round: 1 = load cells with key 0 add, 2..11 = rounds 1..10, 12 = capture
    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_out_valid = r_out_valid;
        w_ctl       = '0;
        w_cap       = 1'b0;
        // drop the result once the sink takes it
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            aes_pkg::ST_IDLE: begin
                if (w_acc && s_axis_tuser != aes_pkg::CMD_LOAD) begin
                    n_state = aes_pkg::ST_RUN;
                    n_round = 4'd1;
                end
            end
            aes_pkg::ST_RUN: begin
                // key for slot k is read when r_round == k, used the cycle after
                if (r_round == 4'd1) begin
                    w_ctl.load = 1'b1;
                end else if (r_round <= 4'(aes_pkg::NUM_ROUNDS + 1)) begin
                    w_ctl.step = 1'b1;
                    w_ctl.mix  = r_round != 4'(aes_pkg::NUM_ROUNDS + 1);
                end
                if (r_round == 4'(aes_pkg::NUM_ROUNDS + 2)) begin
                    // hold here while the previous result still waits
                    if (!r_out_valid || m_axis_tready) begin
                        w_cap       = 1'b1;
                        n_out_valid = 1'b1;
                        n_state     = aes_pkg::ST_IDLE;
                        n_round     = '0;
                    end
                end else begin
                    n_round = r_round + 4'd1;
                end
            end
            default: n_state = aes_pkg::ST_IDLE;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out[63:0], r_out[127:64]};

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aes_pkg::ST_RUN) |-> !s_axis_tready)
        else $error("ready high during encryption");
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped or changed while stalled");
    a_capture_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aes_pkg::ST_RUN && r_round == 4'(aes_pkg::NUM_ROUNDS + 2) &&
         m_axis_tvalid && !m_axis_tready) |=> (r_state == aes_pkg::ST_RUN))
        else $error("capture over an unread result");
endmodule

### tb/tb_aes128_block_encrypt.sv
// Testbench for the AES-128 block encrypt core: random traffic against a predictor.
`timescale 1ns / 1ps

module tb_aes128_block_encrypt;

    typedef struct packed {
        aes_pkg::t_cmd cmd;
        logic [3:0]    slot;
        logic [63:0]   blk_hi;
        logic [63:0]   blk_lo;
    } t_req;

    typedef struct packed {
        logic [63:0] ct_hi;
        logic [63:0] ct_lo;
    } t_ct;

    localparam int  LAST_SLOT   = aes_pkg::NUM_KEYS - 1;
    localparam int  LIMIT_CYCLES = 400000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // tdata: [3:0] key_slot, [67:4] block_high, [131:68] block_low, [135:132] zero
    logic [135:0] s_axis_tdata;
    // tuser: command
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // tdata: [63:0] cipher_high, [127:64] cipher_low
    logic [127:0] m_axis_tdata;

    aes128_block_encrypt dut (.*);

    // predictor state: the round keys as the core should hold them
    logic [127:0] key_sched [aes_pkg::NUM_KEYS];
    t_req   pending_reqs [$];
    t_ct    ciphertext_q [$];
    int     n_errors;
    int     n_loads;
    int     n_blocks;
    int     n_ciphers;
    int     cycle_cnt;
    int     src_gap;
    int     snk_gap;
    bit     calm;
    bit     stim_done;
    // set at the rising edge when the presented item was taken
    bit     s_axis_tready_seen = 1'b0;

    function automatic aes_pkg::t_byte sub_byte(input aes_pkg::t_byte a);
        aes_pkg::t_byte lut [256] = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return lut[a];
    endfunction

    function automatic aes_pkg::t_byte dbl(input aes_pkg::t_byte v);
        return v[7] ? ({v[6:0], 1'b0} ^ 8'h1b) : {v[6:0], 1'b0};
    endfunction

    // Encrypt one block with the predicted key schedule; byte 0 sits in the top bits.
    function automatic t_ct encipher(input logic [127:0] pt);
        aes_pkg::t_byte st [16];
        aes_pkg::t_byte tmp [16];
        aes_pkg::t_byte a0, a1, a2, a3;
        logic [127:0] packed_st;
        for (int i = 0; i < 16; i++) st[i] = pt[127 - 8*i -: 8] ^ key_sched[0][127 - 8*i -: 8];
        for (int rnd = 1; rnd <= aes_pkg::NUM_ROUNDS; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    tmp[4*c + r] = sub_byte(st[4*((c + r) % 4) + r]);
            st = tmp;
            if (rnd != aes_pkg::NUM_ROUNDS) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                    st[4*c]   = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
                    st[4*c+1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
                    st[4*c+2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
                    st[4*c+3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
                end
            end
            for (int i = 0; i < 16; i++) st[i] ^= key_sched[rnd][127 - 8*i -: 8];
        end
        for (int i = 0; i < 16; i++) packed_st[127 - 8*i -: 8] = st[i];
        return '{ct_hi: packed_st[127:64], ct_lo: packed_st[63:0]};
    endfunction

    function automatic logic [63:0] rnd64();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic t_req mk_load(input int slot);
        return '{cmd: aes_pkg::CMD_LOAD, slot: 4'(slot), blk_hi: rnd64(), blk_lo: rnd64()};
    endfunction

    function automatic t_req mk_block();
        // the slot field is don't-care on encrypt, so randomize it too
        return '{cmd: aes_pkg::CMD_CRYPT, slot: 4'($urandom_range(0, 15)),
                 blk_hi: rnd64(), blk_lo: rnd64()};
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // stimulus: directed opener, then random key loads and encrypts
    initial begin
        t_req rq;
        int   r;
        i_rst_n = 1'b0;
        stim_done = 1'b0;
        calm = 1'b0;
        // load every slot first so no encrypt reads an unwritten key
        for (int k = 0; k <= LAST_SLOT; k++) pending_reqs.push_back(mk_load(k));
        pending_reqs.push_back('{aes_pkg::CMD_CRYPT, 4'd0, 64'h0, 64'h0});
        pending_reqs.push_back('{aes_pkg::CMD_CRYPT, 4'hf, '1, '1});
        pending_reqs.push_back('{aes_pkg::CMD_CRYPT, 4'd10,
                                 64'h0011223344556677, 64'h8899aabbccddeeff});
        // out-of-range slots must be dropped without touching any key
        pending_reqs.push_back('{aes_pkg::CMD_LOAD, 4'd11, '1, '1});
        pending_reqs.push_back('{aes_pkg::CMD_LOAD, 4'd15, 64'h0, 64'h0});
        pending_reqs.push_back('{aes_pkg::CMD_CRYPT, 4'd11, 64'h8000000000000001, 64'h1});
        pending_reqs.push_back('{aes_pkg::CMD_LOAD, 4'd0, '1, '1});
        pending_reqs.push_back('{aes_pkg::CMD_LOAD, 4'd10, 64'h0, 64'h0});
        pending_reqs.push_back('{aes_pkg::CMD_CRYPT, 4'd5,
                                 64'hffffffff00000000, 64'h00000000ffffffff});
        // random part: mostly encrypts, with key rewrites and dropped loads
        for (int n = 0; n < 900; n++) begin
            r = $urandom_range(0, 99);
            if (r < 70)      rq = mk_block();
            else if (r < 95) rq = mk_load($urandom_range(0, LAST_SLOT));
            else             rq = mk_load($urandom_range(LAST_SLOT + 1, 15));
            pending_reqs.push_back(rq);
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (pending_reqs.size() < 100);
        calm = 1'b1;
        wait (pending_reqs.size() == 0 && !s_axis_tvalid);
        wait (ciphertext_q.size() == 0);
        repeat (40) @(posedge i_clk);
        stim_done = 1'b1;
    end

    // source: present items at the falling edge, random gap bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            src_gap       <= 0;
        end else if (!s_axis_tvalid || s_axis_tready_seen) begin
            if (src_gap > 0) begin
                src_gap       <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_reqs[0].cmd;
                s_axis_tdata  <= {4'b0, pending_reqs[0].blk_lo, pending_reqs[0].blk_hi,
                                  pending_reqs[0].slot};
                void'(pending_reqs.pop_front());
                if (!calm && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 13);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink ready: random stall bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            snk_gap       <= 0;
        end else if (snk_gap > 0) begin
            snk_gap       <= snk_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) snk_gap <= $urandom_range(1, 13);
        end
    end

    // monitor: predict on accepted input, check on accepted output
    always @(posedge i_clk) begin
        t_ct exp_ct;
        t_ct got_ct;
        int  errs;
        errs = 0;
        s_axis_tready_seen <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            n_errors  <= 0;
            cycle_cnt <= 0;
            n_loads   <= 0;
            n_blocks  <= 0;
            n_ciphers <= 0;
            for (int k = 0; k < aes_pkg::NUM_KEYS; k++) key_sched[k] = '0;
        end else begin
            cycle_cnt <= cycle_cnt + 1;
            if (s_axis_tvalid && s_axis_tready) begin
                if (aes_pkg::t_cmd'(s_axis_tuser) == aes_pkg::CMD_LOAD) begin
                    if (s_axis_tdata[3:0] <= LAST_SLOT)
                        key_sched[s_axis_tdata[3:0]] =
                            {s_axis_tdata[67:4], s_axis_tdata[131:68]};
                    n_loads <= n_loads + 1;
                end else begin
                    ciphertext_q.push_back(encipher({s_axis_tdata[67:4],
                                                     s_axis_tdata[131:68]}));
                    n_blocks <= n_blocks + 1;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_ct = '{ct_hi: m_axis_tdata[63:0], ct_lo: m_axis_tdata[127:64]};
                n_ciphers <= n_ciphers + 1;
                if (ciphertext_q.size() == 0) begin
                    $error("unexpected ciphertext %h", m_axis_tdata);
                    errs = errs + 1;
                end else begin
                    exp_ct = ciphertext_q.pop_front();
                    if (got_ct.ct_hi !== exp_ct.ct_hi) begin
                        $error("cipher_high expected %h actual %h", exp_ct.ct_hi, got_ct.ct_hi);
                        errs = errs + 1;
                    end
                    if (got_ct.ct_lo !== exp_ct.ct_lo) begin
                        $error("cipher_low expected %h actual %h", exp_ct.ct_lo, got_ct.ct_lo);
                        errs = errs + 1;
                    end
                end
            end
            n_errors <= n_errors + errs;
        end
    end

    // end of run or timeout
    initial begin
        wait (stim_done || cycle_cnt >= LIMIT_CYCLES);
        if (!stim_done) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("SCOREBOARD MISMATCH");
        end else begin
            $display("covered %0d key loads (dropped slots included) and %0d encrypts,",
                     n_loads, n_blocks);
            $display("%0d ciphertexts checked under random source and sink stalls", n_ciphers);
            if (n_errors == 0 && ciphertext_q.size() == 0) begin
                $display("SCOREBOARD CLEAN");
            end else begin
                $display("SCOREBOARD MISMATCH");
            end
        end
        $finish;
    end

endmodule
